@@ rtl/pfdec_pkg.sv @@
// Shared types and constants for the Playfair digram decrypter.
`timescale 1ns / 1ps
package pfdec_pkg;

  localparam int CellCount = 25;
  localparam int Side      = 5;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LetterI = 5'd8;
  localparam letter_t LetterJ = 5'd9;

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5A;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerZ = 8'h7A;

  localparam int CfgDataWidth  = 60;
  localparam int CfgIndexWidth = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_CELLS_LOW = 2'd0,
    CFG_CELLS_MID = 2'd1,
    CFG_CELL_LAST = 2'd2
  } cfg_index_t;

  // Key square, cell k row-major at element k
  typedef letter_t [CellCount-1:0] cell_table_t;

  // Completed pair handed from the pairing stage to the decode stage
  typedef struct packed {
    letter_t first;
    letter_t second;
  } pair_t;

endpackage

@@ rtl/pfdec_pair.sv @@
// Input stage: letter filter, pair assembly and pair register.
`timescale 1ns / 1ps
module pfdec_pair (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            pair_valid,
  input  logic            pair_ready,
  output pfdec_pkg::pair_t pair
);
  import pfdec_pkg::*;

  letter_t held_letter;
  logic    held_valid;
  logic    is_upper;
  logic    is_lower;
  logic    is_letter;
  letter_t letter_raw;
  letter_t letter;
  logic    accept;
  logic    pair_fire;

  // Take a beat whenever the pair slot is empty or drains this cycle
  assign in_ready = !pair_valid || pair_ready;
  assign accept   = in_valid && in_ready;

  // Classify the byte, fold case and merge J into I
  always_comb begin
    is_upper   = (in_byte >= AsciiUpperA) && (in_byte <= AsciiUpperZ);
    is_lower   = (in_byte >= AsciiLowerA) && (in_byte <= AsciiLowerZ);
    is_letter  = is_upper || is_lower;
    letter_raw = is_upper ? 5'(in_byte - AsciiUpperA) : 5'(in_byte - AsciiLowerA);
    letter     = (letter_raw == LetterJ) ? LetterI : letter_raw;
    pair_fire  = is_letter && held_valid && (letter != held_letter);
  end

  // Hold the first letter of a pair; drop a repeat; clear at end of message
  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
    end else if (accept) begin
      if (is_letter && !held_valid) begin
        held_letter <= letter;
        held_valid  <= 1'b1;
      end else if (pair_fire) begin
        held_valid <= 1'b0;
      end
      if (in_last) begin
        held_letter <= '0;
        held_valid  <= 1'b0;
      end
    end
  end

  // Register a completed pair for the decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (in_ready) begin
      pair_valid <= accept && pair_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pair_fire) begin
      pair.first  <= held_letter;
      pair.second <= letter;
    end
  end

endmodule

@@ rtl/pfdec_decode.sv @@
// Decode stage: key square search, Playfair rules and result register.
`timescale 1ns / 1ps
module pfdec_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  pfdec_pkg::cell_table_t cells,
  input  logic                   pair_valid,
  output logic                   pair_ready,
  input  pfdec_pkg::pair_t       pair,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             plain_first,
  output logic [7:0]             plain_second,
  output logic                   letter_absent
);
  import pfdec_pkg::*;

  logic       found1;
  logic       found2;
  coord_t     row1;
  coord_t     col1;
  coord_t     row2;
  coord_t     col2;
  coord_t     orow1;
  coord_t     ocol1;
  coord_t     orow2;
  coord_t     ocol2;
  letter_t    oidx1;
  letter_t    oidx2;
  logic [7:0] first_next;
  logic [7:0] second_next;
  logic       absent_next;

  // Advance into the result register when it is empty or being taken
  assign pair_ready = !out_valid || out_ready;

  // Search all 25 cells; the highest-numbered match wins
  always_comb begin
    found1 = 1'b0;
    found2 = 1'b0;
    row1   = '0;
    col1   = '0;
    row2   = '0;
    col2   = '0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (cells[r*Side+c] == pair.first) begin
          found1 = 1'b1;
          row1   = 3'(r);
          col1   = 3'(c);
        end
        if (cells[r*Side+c] == pair.second) begin
          found2 = 1'b1;
          row2   = 3'(r);
          col2   = 3'(c);
        end
      end
    end
  end

  // Apply the row, column and rectangle rules
  always_comb begin
    orow1 = row1;
    orow2 = row2;
    ocol1 = col2;
    ocol2 = col1;
    if (row1 == row2) begin
      ocol1 = (col1 == '0) ? 3'(Side - 1) : col1 - 3'd1;
      ocol2 = (col2 == '0) ? 3'(Side - 1) : col2 - 3'd1;
    end else if (col1 == col2) begin
      orow1 = (row1 == '0) ? 3'(Side - 1) : row1 - 3'd1;
      orow2 = (row2 == '0) ? 3'(Side - 1) : row2 - 3'd1;
      ocol1 = col1;
      ocol2 = col2;
    end
    oidx1       = 5'(orow1) * 5'(Side) + 5'(ocol1);
    oidx2       = 5'(orow2) * 5'(Side) + 5'(ocol2);
    absent_next = !(found1 && found2);
    first_next  = absent_next ? 8'd0 : AsciiUpperA + 8'(cells[oidx1]);
    second_next = absent_next ? 8'd0 : AsciiUpperA + 8'(cells[oidx2]);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pair_ready) begin
      out_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_ready && pair_valid) begin
      plain_first   <= first_next;
      plain_second  <= second_next;
      letter_absent <= absent_next;
    end
  end

endmodule

@@ rtl/playfair_digram_decrypt.sv @@
// A completing letter's pair passes the pair register, then the result register, to the output.
// Throughput: one input beat per cycle unless m_axis_tready stalls the pair and result registers.
// A non-letter, a first letter or a repeated letter yields no output beat.
// Reset (rst, synchronous): clears the held letter, both stage valids and the key square.
// The key square search is 25 parallel compares per pair letter within the decode stage.
`timescale 1ns / 1ps
module playfair_digram_decrypt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] in_byte
  input  logic                                s_axis_tlast,  // end_of_message
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // [7:0] plain_first, [15:8] plain_second
  output logic                                m_axis_tuser,  // letter_absent
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfdec_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [pfdec_pkg::CfgDataWidth-1:0]  cfg_data
);
  import pfdec_pkg::*;

  logic [CfgDataWidth-1:0] cells_low;
  logic [CfgDataWidth-1:0] cells_mid;
  letter_t                 cell_last;
  cell_table_t             cells;
  logic                    pair_valid;
  logic                    pair_ready;
  pair_t                   pair;
  logic [7:0]              plain_first;
  logic [7:0]              plain_second;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_low <= '0;
      cells_mid <= '0;
      cell_last <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_CELLS_LOW: cells_low <= cfg_data;
        CFG_CELLS_MID: cells_mid <= cfg_data;
        CFG_CELL_LAST: cell_last <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cells = {cell_last, cells_mid, cells_low};

  pfdec_pair u_pair (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .pair_valid(pair_valid),
    .pair_ready(pair_ready),
    .pair      (pair)
  );

  pfdec_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .cells        (cells),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .pair         (pair),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .plain_first  (plain_first),
    .plain_second (plain_second),
    .letter_absent(m_axis_tuser)
  );

  assign m_axis_tdata = {plain_second, plain_first};

endmodule
